// ===== hdl/ecf_pkg.sv =====
// ecf_pkg: shared types and constants of the entitlement message class filter
// no dependencies

package ecf_pkg;

    localparam int MAX_MESSAGE_BYTES = 512;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [15:0] CHECKED_SYSTEM = 16'h0500;
    localparam logic [7:0]  CLASS_MARK     = 8'hE2;
    localparam logic [7:0]  LATE_FLAG      = 8'hD2;
    localparam logic [7:0]  END_MARK       = 8'hEA;

    localparam logic [3:0] SCAN_START_EARLY = 4'd9;
    localparam logic [3:0] SCAN_START_LATE  = 4'd12;
    localparam logic [3:0] LATE_FLAG_POS    = 4'd4;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED_3 = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_3 = 4'd7;

    localparam logic [1:0] VERDICT_UNCHECKED = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT    = 2'd1;
    localparam logic [1:0] VERDICT_BLOCKED   = 2'd2;
    localparam logic [1:0] VERDICT_NO_MATCH  = 2'd3;

    typedef struct packed {
        logic [255:0] blocked;
        logic [255:0] allowed;
    } class_maps_t;

endpackage

// ===== hdl/ecm_class_filter_unit.sv =====
// ecm_class_filter_unit: class filter for entitlement message byte streams
// depends on ecf_pkg, ecf_cfg_regs, ecf_scan
// a last beat goes through the input register and result register to m_tvalid
// throughput: one byte beat per cycle; a last beat stalls on an unaccepted verdict
// reset: aresetn low clears bitmaps, message state and both valid flags

module ecm_class_filter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // data_byte[7:0], system_id[23:8]
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,  // verdict[1:0], classes_found[9:2]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import ecf_pkg::*;

    class_maps_t maps;
    logic [1:0]  verdict;
    logic [7:0]  classes_found;

    ecf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .maps      (maps)
    );

    ecf_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata[7:0]),
        .in_system_id (s_tdata[23:8]),
        .in_last      (s_tlast),
        .maps         (maps),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_verdict  (verdict),
        .out_classes  (classes_found)
    );

    assign m_tdata = {6'd0, classes_found, verdict};

endmodule

// ===== hdl/ecf_cfg_regs.sv =====
// ecf_cfg_regs: blocked and allowed class bitmap registers
// depends on ecf_pkg

module ecf_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ecf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                  cfg_data,
    output ecf_pkg::class_maps_t         maps
);
    import ecf_pkg::*;

    logic [255:0] blocked_reg;
    logic [255:0] allowed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blocked_reg <= '0;
            allowed_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLOCKED_0: blocked_reg[63:0]    <= cfg_data;
                CFG_BLOCKED_1: blocked_reg[127:64]  <= cfg_data;
                CFG_BLOCKED_2: blocked_reg[191:128] <= cfg_data;
                CFG_BLOCKED_3: blocked_reg[255:192] <= cfg_data;
                CFG_ALLOWED_0: allowed_reg[63:0]    <= cfg_data;
                CFG_ALLOWED_1: allowed_reg[127:64]  <= cfg_data;
                CFG_ALLOWED_2: allowed_reg[191:128] <= cfg_data;
                CFG_ALLOWED_3: allowed_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign maps.blocked = blocked_reg;
    assign maps.allowed = allowed_reg;

endmodule

// ===== hdl/ecf_scan.sv =====
// ecf_scan: input register, per-byte scan state update and verdict register
// depends on ecf_pkg

module ecf_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic [15:0]          in_system_id,
    input  logic                 in_last,
    input  ecf_pkg::class_maps_t maps,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_verdict,
    output logic [7:0]           out_classes
);
    import ecf_pkg::*;

    localparam logic [2:0] MODE_HEADER = 3'd0;
    localparam logic [2:0] MODE_SCAN   = 3'd1;
    localparam logic [2:0] MODE_LEN    = 3'd2;
    localparam logic [2:0] MODE_SKIP   = 3'd3;
    localparam logic [2:0] MODE_DONE   = 3'd4;

    function automatic logic [2:0] scan_of(input logic [7:0] b);
        if (b == CLASS_MARK)    return MODE_LEN;
        else if (b == END_MARK) return MODE_DONE;
        else                    return MODE_SCAN;
    endfunction

    // input stage
    logic        ivalid_reg;
    logic [7:0]  ibyte_reg;
    logic [15:0] isys_reg;
    logic        ilast_reg;

    // per-message state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       mode_reg, mode_next;
    logic             late_reg, late_next;
    logic [7:0]       skip_reg, skip_next;
    logic             blk_reg, blk_next;
    logic             alw_reg, alw_next;
    logic [7:0]       cnt_reg, cnt_next;

    // result stage
    logic       ovalid_reg;
    logic [1:0] overdict_reg, overdict_next;
    logic [7:0] ocnt_reg;

    logic       out_free;
    logic       advance;
    logic [2:0] mode_eff;
    logic       take;
    logic       any_blk;
    logic       any_alw;

    assign out_free = !ovalid_reg || out_ready;
    assign advance  = ivalid_reg && (!ilast_reg || out_free);
    assign in_ready = !ivalid_reg || advance;
    assign any_blk  = |maps.blocked;
    assign any_alw  = |maps.allowed;

    always_comb begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        late_next = late_reg;
        skip_next = skip_reg;
        blk_next  = blk_reg;
        alw_next  = alw_reg;
        cnt_next  = cnt_reg;
        mode_eff  = mode_reg;
        take      = 1'b0;
        overdict_next = VERDICT_ACCEPT;

        if (pos_reg < POS_W'(MAX_MESSAGE_BYTES)) begin
            if (pos_reg == POS_W'(LATE_FLAG_POS))
                late_next = (ibyte_reg == LATE_FLAG);
            if (mode_reg == MODE_HEADER &&
                pos_reg >= POS_W'(late_next ? SCAN_START_LATE : SCAN_START_EARLY))
                mode_eff = MODE_SCAN;
            mode_next = mode_eff;
            case (mode_eff)
                MODE_SCAN: mode_next = scan_of(ibyte_reg);
                MODE_LEN: begin
                    if (ibyte_reg == 8'd0) begin
                        take = 1'b1;
                    end else begin
                        skip_next = ibyte_reg - 8'd1;
                        mode_next = MODE_SKIP;
                    end
                end
                MODE_SKIP: begin
                    if (skip_reg == 8'd0) take = 1'b1;
                    else                  skip_next = skip_reg - 8'd1;
                end
                default: ;
            endcase
            pos_next = pos_reg + POS_W'(1);
        end

        if (take) begin
            if (maps.blocked[ibyte_reg]) begin
                blk_next  = 1'b1;
                mode_next = MODE_DONE;
            end else begin
                if (cnt_reg != 8'hFF) cnt_next = cnt_reg + 8'd1;
                if (maps.allowed[ibyte_reg]) alw_next = 1'b1;
                mode_next = scan_of(ibyte_reg);
            end
        end

        if (isys_reg != CHECKED_SYSTEM)
            overdict_next = VERDICT_UNCHECKED;
        else if (!any_blk && !any_alw)
            overdict_next = VERDICT_ACCEPT;
        else if (blk_next)
            overdict_next = VERDICT_BLOCKED;
        else if (cnt_next != 8'd0 && any_alw && !alw_next)
            overdict_next = VERDICT_NO_MATCH;
        else
            overdict_next = VERDICT_ACCEPT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ivalid_reg <= 1'b0;
        end else if (in_ready) begin
            ivalid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            ibyte_reg <= in_byte;
            isys_reg  <= in_system_id;
            ilast_reg <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            mode_reg <= MODE_HEADER;
            late_reg <= 1'b0;
            skip_reg <= '0;
            blk_reg  <= 1'b0;
            alw_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else if (advance) begin
            if (ilast_reg) begin
                pos_reg  <= '0;
                mode_reg <= MODE_HEADER;
                late_reg <= 1'b0;
                skip_reg <= '0;
                blk_reg  <= 1'b0;
                alw_reg  <= 1'b0;
                cnt_reg  <= '0;
            end else begin
                pos_reg  <= pos_next;
                mode_reg <= mode_next;
                late_reg <= late_next;
                skip_reg <= skip_next;
                blk_reg  <= blk_next;
                alw_reg  <= alw_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (advance && ilast_reg) begin
            ovalid_reg <= 1'b1;
        end else if (out_ready) begin
            ovalid_reg <= 1'b0;
        end
        if (advance && ilast_reg) begin
            overdict_reg <= overdict_next;
            ocnt_reg     <= cnt_next;
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_verdict = overdict_reg;
    assign out_classes = ocnt_reg;

endmodule

// ===== hdl/ecf_checker.sv =====
// ecf_checker: port-level assertions for ecm_class_filter_unit
// depends on ecf_pkg; bound to the top level below

module ecf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import ecf_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("verdict without a last byte two cycles before");

    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == VERDICT_NO_MATCH |-> m_tdata[9:2] != 8'd0)
        else $error("no-match verdict with zero classes");

endmodule

bind ecm_class_filter_unit ecf_checker u_ecf_checker (.*);

// ===== test/ecm_class_filter_unit_tb.sv =====
// ecm_class_filter_unit_tb: self-checking bench for the entitlement message class filter
// streams directed and random messages with random gaps on both sides, predicts each verdict
// depends on ecf_pkg and ecm_class_filter_unit

module ecm_class_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TARGET_BYTES   = 1950;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;
    localparam logic [CFG_IDX_W-1:0] MAP_REGS [8] = '{
        CFG_BLOCKED_0, CFG_BLOCKED_1, CFG_BLOCKED_2, CFG_BLOCKED_3,
        CFG_ALLOWED_0, CFG_ALLOWED_1, CFG_ALLOWED_2, CFG_ALLOWED_3
    };

    typedef enum logic [2:0] {
        MODE_HEADER, MODE_SCAN, MODE_LEN, MODE_SKIP, MODE_DONE
    } scan_mode_e;

    typedef enum int {
        MAPS_EMPTY, MAPS_ALL_BLOCKED, MAPS_ALL_ALLOWED, MAPS_ALL_ONES,
        MAPS_POOL, MAPS_ALLOW_ONLY, MAPS_RANDOM
    } map_kind_e;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] classes;
    } verdict_t;

    typedef logic [7:0] msg_t[$];

    class verdict_board;
        logic [255:0]     blocked_map;
        logic [255:0]     allowed_map;
        logic [POS_W-1:0] position;
        scan_mode_e       mode;
        bit               late_start;
        logic [7:0]       skip_left;
        bit               blocked_hit;
        bit               allowed_hit;
        logic [7:0]       class_count;
        verdict_t         verdict_q[$];
        int               mismatches;

        function new();
            blocked_map = '0;
            allowed_map = '0;
            mismatches  = 0;
            clear_message();
        endfunction

        function void clear_message();
            position    = '0;
            mode        = MODE_HEADER;
            late_start  = 1'b0;
            skip_left   = '0;
            blocked_hit = 1'b0;
            allowed_hit = 1'b0;
            class_count = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
            if (idx <= CFG_BLOCKED_3) begin
                blocked_map[int'(idx - CFG_BLOCKED_0) * 64 +: 64] = data;
            end else if (idx <= CFG_ALLOWED_3) begin
                allowed_map[int'(idx - CFG_ALLOWED_0) * 64 +: 64] = data;
            end
        endfunction

        function void scan_byte(logic [7:0] b);
            if (b == CLASS_MARK) mode = MODE_LEN;
            else if (b == END_MARK) mode = MODE_DONE;
            else mode = MODE_SCAN;
        endfunction

        function void take_class(logic [7:0] b);
            if (blocked_map[b]) begin
                blocked_hit = 1'b1;
                mode = MODE_DONE;
            end else begin
                if (class_count != 8'hFF) class_count++;
                if (allowed_map[b]) allowed_hit = 1'b1;
                scan_byte(b);
            end
        endfunction

        // one accepted byte beat; a last beat queues the verdict it must produce
        function void note_byte(logic [7:0] b, logic [15:0] sys, logic last);
            verdict_t exp;
            if (position < MAX_MESSAGE_BYTES) begin
                if (position == LATE_FLAG_POS) late_start = (b == LATE_FLAG);
                if (mode == MODE_HEADER &&
                    position >= (late_start ? SCAN_START_LATE : SCAN_START_EARLY))
                    mode = MODE_SCAN;
                case (mode)
                    MODE_SCAN: scan_byte(b);
                    MODE_LEN: begin
                        if (b == 0) begin
                            take_class(b);
                        end else begin
                            skip_left = b - 8'd1;
                            mode = MODE_SKIP;
                        end
                    end
                    MODE_SKIP: begin
                        if (skip_left == 0) take_class(b);
                        else skip_left--;
                    end
                    default: ;
                endcase
                position++;
            end
            if (last) begin
                if (sys != CHECKED_SYSTEM) exp.verdict = VERDICT_UNCHECKED;
                else if (blocked_map == '0 && allowed_map == '0) exp.verdict = VERDICT_ACCEPT;
                else if (blocked_hit) exp.verdict = VERDICT_BLOCKED;
                else if (class_count != 0 && allowed_map != '0 && !allowed_hit)
                    exp.verdict = VERDICT_NO_MATCH;
                else exp.verdict = VERDICT_ACCEPT;
                exp.classes = class_count;
                verdict_q.push_back(exp);
                clear_message();
            end
        endfunction

        function void check_result(logic [1:0] verdict, logic [7:0] classes);
            verdict_t exp;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: verdict %0d classes %0d with none pending",
                             $time, verdict, classes);
            end else begin
                exp = verdict_q.pop_front();
                if (exp.verdict !== verdict || exp.classes !== classes) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: expected verdict %0d classes %0d,",
                                  " got verdict %0d classes %0d"},
                                 $time, exp.verdict, exp.classes, verdict, classes);
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [15:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data  = '0;

    verdict_board board;
    bit           steady      = 1'b0;
    int           bytes_sent  = 0;
    int           quiet_cycles = 0;
    int           ready_hold  = 0;
    int           ready_roll;
    logic [7:0]   class_pool [8];

    ecm_class_filter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
            if (m_tvalid && m_tready) board.check_result(m_tdata[1:0], m_tdata[9:2]);
            if (s_tvalid && s_tready) board.note_byte(s_tdata[7:0], s_tdata[23:8], s_tlast);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (steady) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            m_tready   <= (ready_roll < 65);
            ready_hold <= (ready_roll < 65) ? $urandom_range(0, 15) :
                          (ready_roll < 93) ? $urandom_range(0, 3) : $urandom_range(20, 50);
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic msg_t msg_header(input bit late);
        msg_t       hdr;
        logic [7:0] b;
        int         k;
        for (k = 0; k < (late ? SCAN_START_LATE : SCAN_START_EARLY); k++) begin
            b = 8'($urandom_range(0, 255));
            if (k == LATE_FLAG_POS) b = late ? LATE_FLAG : ((b == LATE_FLAG) ? ~LATE_FLAG : b);
            hdr.push_back(b);
        end
        return hdr;
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CLASS_MARK || b == END_MARK) b ^= 8'h01;
        return b;
    endfunction

    function automatic logic [7:0] pick_class();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return class_pool[$urandom_range(0, 7)];
        if (r < 65) return CLASS_MARK;
        if (r < 70) return END_MARK;
        if (r < 75) return 8'h00;
        if (r < 80) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_message(input msg_t msg, input logic [15:0] sys);
        int i;
        int gap;
        for (i = 0; i < msg.size(); i++) begin
            s_tdata  <= {sys, msg[i]};
            s_tlast  <= (i == msg.size() - 1);
            s_tvalid <= 1'b1;
            do @(posedge aclk); while (!s_tready);
            bytes_sent++;
            gap = pick_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic load_maps(input logic [255:0] blk, input logic [255:0] alw,
                             input bit poke_unused);
        int k;
        for (k = 0; k < 9; k++) begin
            if (k == 8 && !poke_unused) break;
            if (k < 4) begin
                cfg_index <= MAP_REGS[k];
                cfg_data  <= blk[k*64 +: 64];
            end else if (k < 8) begin
                cfg_index <= MAP_REGS[k];
                cfg_data  <= alw[(k-4)*64 +: 64];
            end else begin
                cfg_index <= CFG_UNUSED;
                cfg_data  <= {$urandom, $urandom};
            end
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic start_phase(input map_kind_e kind);
        logic [255:0] blk;
        logic [255:0] alw;
        int           k;
        wait_drained();
        for (k = 0; k < 8; k++) class_pool[k] = 8'($urandom_range(0, 255));
        blk = '0;
        alw = '0;
        case (kind)
            MAPS_EMPTY: ;
            MAPS_ALL_BLOCKED: blk = '1;
            MAPS_ALL_ALLOWED: alw = '1;
            MAPS_ALL_ONES: begin
                blk = '1;
                alw = '1;
            end
            MAPS_POOL, MAPS_ALLOW_ONLY: begin
                for (k = 0; k < 8; k++) begin
                    if (kind == MAPS_POOL && $urandom_range(0, 3) == 0) blk[class_pool[k]] = 1'b1;
                    if ($urandom_range(0, 1) == 1) alw[class_pool[k]] = 1'b1;
                end
            end
            default: begin
                for (k = 0; k < 4; k++) begin
                    blk[k*64 +: 64] = {$urandom, $urandom};
                    alw[k*64 +: 64] = {$urandom, $urandom};
                end
            end
        endcase
        steady <= ($urandom_range(0, 4) == 0);
        load_maps(blk, alw, $urandom_range(0, 3) == 0);
    endtask

    task automatic build_message(input bit go_long, output msg_t msg);
        int         r;
        int         k;
        int         n;
        bit         late;
        logic [7:0] len;
        msg = {};
        r = $urandom_range(0, 99);
        if (go_long || r < 1) begin
            // runs past the position limit, two bytes per class
            n = $urandom_range(MAX_MESSAGE_BYTES + 1, MAX_MESSAGE_BYTES + 24);
            msg = msg_header(1'b0);
            while (msg.size() < n) begin
                msg.push_back(CLASS_MARK);
                msg.push_back(8'h01);
            end
            return;
        end
        if (r < 8) begin
            n = $urandom_range(1, 24);
            for (k = 0; k < n; k++) begin
                r = $urandom_range(0, 9);
                msg.push_back(r < 3 ? CLASS_MARK : r < 4 ? END_MARK : r < 5 ? LATE_FLAG :
                              8'($urandom_range(0, 255)));
            end
            return;
        end
        late = $urandom_range(0, 1);
        msg = msg_header(late);
        if (r < 12) begin
            // ends before the scan starts
            n = $urandom_range(1, msg.size());
            while (msg.size() > n) void'(msg.pop_back());
            return;
        end
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) begin
            repeat ($urandom_range(0, 2)) msg.push_back(plain_byte());
            msg.push_back(CLASS_MARK);
            if ($urandom_range(0, 19) == 0) return;
            r = $urandom_range(0, 99);
            len = (r < 20) ? 8'd0 : (r < 60) ? 8'd1 :
                  (r < 92) ? 8'($urandom_range(2, 4)) : 8'($urandom_range(5, 255));
            msg.push_back(len);
            if (len == 0) continue;
            if ($urandom_range(0, 19) == 0) return;
            repeat (len - 1) msg.push_back(plain_byte());
            msg.push_back(pick_class());
        end
        if ($urandom_range(0, 99) < 40) msg.push_back(END_MARK);
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic directed_part();
        msg_t         msg;
        logic [255:0] blk;
        logic [255:0] alw;
        blk = '0;
        alw = '0;
        blk[8'h40]      = 1'b1;
        alw[8'h00]      = 1'b1;
        alw[8'h21]      = 1'b1;
        alw[CLASS_MARK] = 1'b1;
        load_maps(blk, alw, 1'b1);

        // zero length, a class that is a marker, end marker
        msg = msg_header(1'b0);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h00);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h01);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h01);
        msg.push_back(8'h21);
        msg.push_back(END_MARK);
        msg.push_back(8'hFF);
        send_message(msg, CHECKED_SYSTEM);

        // blocked class under another system
        msg = msg_header(1'b1);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h01);
        msg.push_back(8'h40);
        send_message(msg, 16'hFFFF);

        // ends before the scan starts
        msg = {};
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h01);
        msg.push_back(8'h21);
        send_message(msg, CHECKED_SYSTEM);

        // class byte past the end
        msg = msg_header(1'b0);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h05);
        msg.push_back(8'h33);
        send_message(msg, 16'h0000);

        // blocked class, late start
        msg = msg_header(1'b1);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h01);
        msg.push_back(8'h40);
        send_message(msg, CHECKED_SYSTEM);

        // class without an allowed bit
        msg = msg_header(1'b0);
        msg.push_back(CLASS_MARK);
        msg.push_back(8'h01);
        msg.push_back(8'h55);
        send_message(msg, CHECKED_SYSTEM);
    endtask

    task automatic random_part();
        msg_t       msg;
        int         phase_no;
        int         phase_left;
        bit         go_long;
        logic [15:0] sys;
        phase_no   = 0;
        phase_left = 0;
        while (bytes_sent < TARGET_BYTES) begin
            go_long = 1'b0;
            if (phase_left == 0) begin
                start_phase(phase_no <= int'(MAPS_RANDOM) ? map_kind_e'(phase_no) :
                            map_kind_e'($urandom_range(0, int'(MAPS_RANDOM))));
                phase_no++;
                phase_left = $urandom_range(4, 10);
                go_long = (phase_no == int'(MAPS_ALL_ALLOWED) + 1);
            end
            build_message(go_long, msg);
            sys = ($urandom_range(0, 99) < 85) ? CHECKED_SYSTEM : 16'($urandom_range(0, 65535));
            send_message(msg, sys);
            phase_left--;
            if ($urandom_range(0, 99) < 3) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        random_part();
        repeat (8) @(posedge aclk);
        if (board.mismatches == 0 && board.verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            if (board.verdict_q.size() != 0)
                $display("%0d verdicts never arrived", board.verdict_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ecf_pkg.sv
hdl/ecf_cfg_regs.sv
hdl/ecf_scan.sv
hdl/ecm_class_filter_unit.sv
hdl/ecf_checker.sv
test/ecm_class_filter_unit_tb.sv
